[hw/rtl/lzd_pkg.sv]
// Shared types and constants of the LZ77 stream decompressor.
package lzd_pkg;

  // Width of the raw length field in the stream header.
  localparam int unsigned HDR_LEN_W = 24;
  // Width of a match distance (1 to 4096) and of a match length (3 to 18).
  localparam int unsigned DIST_W = 13;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned MATCH_LEN_BIAS = 3;
  localparam int unsigned TOKENS_PER_FLAG = 8;
  localparam int unsigned TOK_SEL_W = 3;
  localparam int unsigned TOK_IDX_W = 4;
  localparam logic [1:0] HDR_LAST = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FLAG   = 3'd1,
    PH_TOKEN  = 3'd2,
    PH_MATCH2 = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_READ = 2'd1,
    SQ_EMIT = 2'd2
  } seq_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eos;
  } out_item_t;

endpackage

[hw/rtl/lzd_history.sv]
// History window memory with one write port and one registered read port.
module lzd_history #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lzd_out_reg.sv]
// Output register stage that holds one result byte while the sink stalls.
module lzd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lzd_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o,
  output logic               end_of_stream_o
);
  import lzd_pkg::*;

  logic      valid_d, valid_q;
  out_item_t item_q;

  // The register may be reloaded in the cycle its current byte is transferred.
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = item_q.data;
  assign last_of_run_o   = item_q.last;
  assign end_of_stream_o = item_q.eos;

endmodule

[hw/rtl/lz77_stream_decompressor_top.sv]
// Top level: stream parser and match copy sequencer of the LZ77 decompressor.
// Header, flag and match first bytes produce no output.
// A literal byte is presented in the cycle after its input transfer.
// A match copies 3 to 18 bytes, fewer if the stream ends first, each by a
// history read, then emit and write back; the input stays stalled meanwhile.
// Reset clears parser and sequencer state at once, not the history memory.
module lz77_stream_decompressor_top #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned LENGTH_CAP   = 1048576
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       end_of_stream_o
);
  import lzd_pkg::*;

  localparam int unsigned LW = $clog2(LENGTH_CAP + 1);
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = (LW > DIST_W) ? LW : DIST_W;

  seq_e                  seq_d, seq_q;
  phase_e                phase_d, phase_q;
  logic [LW-1:0]         bw_d, bw_q;
  logic [LW-1:0]         target_d, target_q;
  logic [HDR_LEN_W-1:0]  acc_d, acc_q;
  logic [1:0]            hdr_d, hdr_q;
  logic [7:0]            flags_d, flags_q;
  logic [TOK_IDX_W-1:0]  idx_d, idx_q;
  logic [7:0]            mfb_d, mfb_q;
  logic [LEN_W-1:0]      cnt_d, cnt_q;
  logic [DIST_W-1:0]     dist_d, dist_q;
  logic                  zero_d, zero_q;

  logic                  accept;
  logic                  out_ready;
  logic                  out_load;
  out_item_t             out_item;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [7:0]            mem_rdata;

  phase_e                cur_phase;
  logic [1:0]            cur_hdr;
  logic [HDR_LEN_W-1:0]  acc_base, acc_new;
  logic [LW-1:0]         len_capped;
  logic                  flag_bit;
  logic [LW-1:0]         bw_inc;
  logic                  at_end;
  logic                  fin;
  logic [TOK_IDX_W-1:0]  idx_inc;
  logic [CW-1:0]         bw_ext, dist_ext;
  logic [CW-1:0]         src_addr;
  logic [7:0]            emit_val;

  // Shared position arithmetic used by literals and by every copied byte.
  assign bw_inc   = bw_q + LW'(1);
  assign at_end   = (bw_inc == target_q);
  assign bw_ext   = CW'(bw_q);
  assign dist_ext = CW'(dist_q);
  assign src_addr = bw_ext - dist_ext;
  assign fin      = (cnt_q == LEN_W'(1)) || at_end;
  assign idx_inc  = idx_q + TOK_IDX_W'(1);
  assign emit_val = zero_q ? 8'h00 : mem_rdata;

  // A start mark turns the byte into header byte zero of a fresh stream.
  assign cur_phase = start_of_stream_i ? PH_HEADER : phase_q;
  assign cur_hdr   = start_of_stream_i ? 2'd0 : hdr_q;
  assign acc_base  = start_of_stream_i ? '0 : acc_q;
  assign flag_bit  = flags_q[TOK_SEL_W'(TOKENS_PER_FLAG - 1) - idx_q[TOK_SEL_W-1:0]];

  always_comb begin
    acc_new = acc_base;
    case (cur_hdr)
      2'd1:    acc_new = acc_base | HDR_LEN_W'(in_byte_i);
      2'd2:    acc_new = acc_base | (HDR_LEN_W'(in_byte_i) << 8);
      2'd3:    acc_new = acc_base | (HDR_LEN_W'(in_byte_i) << 16);
      default: acc_new = acc_base;
    endcase
  end

  assign len_capped = (acc_new > HDR_LEN_W'(LENGTH_CAP)) ? LW'(LENGTH_CAP)
                                                         : acc_new[LW-1:0];

  // Handshake, memory and output stage control.
  always_comb begin
    in_stall_o     = !((seq_q == SQ_IDLE) && out_ready);
    accept         = in_valid_i && !in_stall_o;
    mem_re         = (seq_q == SQ_READ);
    mem_raddr      = src_addr[AW-1:0];
    out_load       = 1'b0;
    out_item.data  = in_byte_i;
    out_item.last  = 1'b1;
    out_item.eos   = at_end;
    case (seq_q)
      SQ_IDLE: begin
        out_load = accept && (cur_phase == PH_TOKEN) && !flag_bit;
      end
      SQ_EMIT: begin
        out_load      = out_ready;
        out_item.data = emit_val;
        out_item.last = fin;
      end
      default: out_load = 1'b0;
    endcase
  end

  // Next state of the parser and of the copy sequencer.
  always_comb begin
    seq_d    = seq_q;
    phase_d  = phase_q;
    bw_d     = bw_q;
    target_d = target_q;
    acc_d    = acc_q;
    hdr_d    = hdr_q;
    flags_d  = flags_q;
    idx_d    = idx_q;
    mfb_d    = mfb_q;
    cnt_d    = cnt_q;
    dist_d   = dist_q;
    zero_d   = zero_q;
    case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          if (start_of_stream_i) begin
            bw_d     = '0;
            target_d = '0;
            flags_d  = '0;
            idx_d    = '0;
            mfb_d    = '0;
          end
          case (cur_phase)
            PH_HEADER: begin
              acc_d = acc_new;
              if (cur_hdr == HDR_LAST) begin
                hdr_d    = 2'd0;
                target_d = len_capped;
                phase_d  = (len_capped == '0) ? PH_DONE : PH_FLAG;
              end else begin
                hdr_d   = cur_hdr + 2'd1;
                phase_d = PH_HEADER;
              end
            end
            PH_FLAG: begin
              flags_d = in_byte_i;
              idx_d   = '0;
              phase_d = PH_TOKEN;
            end
            PH_TOKEN: begin
              if (flag_bit) begin
                mfb_d   = in_byte_i;
                phase_d = PH_MATCH2;
              end else begin
                bw_d  = bw_inc;
                idx_d = idx_inc;
                if (at_end) begin
                  phase_d = PH_DONE;
                end else if (idx_inc >= TOK_IDX_W'(TOKENS_PER_FLAG)) begin
                  phase_d = PH_FLAG;
                end else begin
                  phase_d = PH_TOKEN;
                end
              end
            end
            PH_MATCH2: begin
              cnt_d  = LEN_W'(mfb_q[7:4]) + LEN_W'(MATCH_LEN_BIAS);
              dist_d = DIST_W'({mfb_q[3:0], in_byte_i}) + DIST_W'(1);
              seq_d  = SQ_READ;
            end
            default: phase_d = phase_q;
          endcase
        end
      end
      SQ_READ: begin
        // Sources before the first output byte of the stream read as zero.
        zero_d = (bw_ext < dist_ext);
        seq_d  = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (out_ready) begin
          bw_d  = bw_inc;
          cnt_d = cnt_q - LEN_W'(1);
          if (fin) begin
            seq_d = SQ_IDLE;
            idx_d = idx_inc;
            if (at_end) begin
              phase_d = PH_DONE;
            end else if (idx_inc >= TOK_IDX_W'(TOKENS_PER_FLAG)) begin
              phase_d = PH_FLAG;
            end else begin
              phase_d = PH_TOKEN;
            end
          end else begin
            seq_d = SQ_READ;
          end
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= SQ_IDLE;
      phase_q  <= PH_HEADER;
      bw_q     <= '0;
      target_q <= '0;
      acc_q    <= '0;
      hdr_q    <= 2'd0;
      flags_q  <= '0;
      idx_q    <= '0;
      mfb_q    <= '0;
      cnt_q    <= '0;
    end else begin
      seq_q    <= seq_d;
      phase_q  <= phase_d;
      bw_q     <= bw_d;
      target_q <= target_d;
      acc_q    <= acc_d;
      hdr_q    <= hdr_d;
      flags_q  <= flags_d;
      idx_q    <= idx_d;
      mfb_q    <= mfb_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    zero_q <= zero_d;
  end

  lzd_history #(
    .DEPTH(WINDOW_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (out_load),
    .waddr_i (bw_ext[AW-1:0]),
    .wdata_i (out_item.data),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lzd_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_load),
    .item_i          (out_item),
    .ready_o         (out_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_stream_o (end_of_stream_o)
  );

`ifndef SYNTHESIS
  a_bw_le_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bw_q <= target_q)
    else $error("output count passed the stream length");

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_READ) |=> (seq_q == SQ_EMIT))
    else $error("history read not followed by an emit cycle");

  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SQ_IDLE) |-> (cnt_q != '0))
    else $error("match copy running with no bytes left");

  a_eos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_stream_o) |-> last_of_run_o)
    else $error("end of stream byte not marked as last of run");
`endif

endmodule

[test/lz77_stream_decompressor_top_test.sv]
// Self-checking testbench of the LZ77 stream decompressor against a behavioral decoder.
`timescale 1ns / 100ps

module lz77_stream_decompressor_top_test;
  import lzd_pkg::*;

  localparam int unsigned WINDOW = 4096;
  localparam int unsigned CAP = 1048576;
  localparam int unsigned RAND_ITEMS = 40;
  localparam int unsigned DEEP_LENGTH = 4160;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] b;
    logic       sos;
  } stream_byte_t;

  // One row of the directed table. Where typed is set, n bytes of value d are
  // expected, and eos tells whether the final one closes the stream.
  typedef struct packed {
    logic [7:0] b;
    logic       sos;
    logic       typed;
    logic [4:0] n;
    logic [7:0] d;
    logic       eos;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       start_of_stream_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       end_of_stream_o;

  lz77_stream_decompressor_top #(
    .WINDOW_DEPTH(WINDOW),
    .LENGTH_CAP  (CAP)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .start_of_stream_i(start_of_stream_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_stream_o  (end_of_stream_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decoder state.
  logic [7:0]          hist_mem [WINDOW];
  logic [20:0]         out_count;
  logic [20:0]         out_target;
  logic [HDR_LEN_W-1:0] hdr_len;
  phase_e              phase;
  logic [1:0]          hdr_idx;
  logic [7:0]          flag_bits;
  logic [3:0]          tok_idx;
  logic [7:0]          match_hi;

  out_item_t    decoded [$];
  out_item_t    expected_bytes [$];
  stream_byte_t stream_bytes [$];

  bit          calm = 1'b0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_checked = 0;
  int unsigned items_sent = 0;
  int unsigned streams_run = 0;
  int unsigned out_hold = 0;
  out_item_t   head;

  row_t directed_rows [0:25] = '{
    // No start mark after reset: header with length 5.
    '{8'h10, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h05, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h40, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd1, 8'h00, 1'b0},
    // Match of 18 reaching before the stream, cut to the 4 bytes that remain.
    '{8'hF0, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h05, 1'b0, 1'b1, 5'd4, 8'h00, 1'b1},
    // Zero length header, then a byte that must be ignored.
    '{8'hFF, 1'b1, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'hAB, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    // Length 25: extreme literals, shortest and longest matches.
    '{8'h10, 1'b1, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h19, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h30, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd1, 8'hFF, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd1, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'd18, 8'h00, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0},
    '{8'hA5, 1'b0, 1'b1, 5'd1, 8'hA5, 1'b1}
  };

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
    err_count++;
  endtask

  task automatic emit_byte(input logic [7:0] v);
    out_item_t o;
    hist_mem[out_count[11:0]] = v;
    out_count = out_count + 21'd1;
    o.data = v;
    o.last = 1'b0;
    o.eos = (out_count == out_target);
    decoded.push_back(o);
  endtask

  task automatic advance_token();
    tok_idx = tok_idx + 4'd1;
    if (out_count >= out_target) phase = PH_DONE;
    else if (tok_idx >= 4'd8) phase = PH_FLAG;
    else phase = PH_TOKEN;
  endtask

  // Decodes one compressed byte into the decoded queue.
  task automatic decode_byte(input logic [7:0] b, input logic sos);
    logic [4:0]  mlen;
    logic [12:0] mdist;
    logic [20:0] src;
    logic [7:0]  v;
    decoded.delete();
    if (sos) begin
      out_count = '0;
      out_target = '0;
      hdr_len = '0;
      hdr_idx = '0;
      flag_bits = '0;
      tok_idx = '0;
      match_hi = '0;
      phase = PH_HEADER;
    end
    case (phase)
      PH_HEADER: begin
        if (hdr_idx != 2'd0) hdr_len = hdr_len | ({16'h0, b} << (8 * (hdr_idx - 1)));
        if (hdr_idx == HDR_LAST) begin
          hdr_idx = '0;
          out_target = (hdr_len > CAP) ? CAP[20:0] : hdr_len[20:0];
          phase = (out_target == 21'd0) ? PH_DONE : PH_FLAG;
        end else begin
          hdr_idx = hdr_idx + 2'd1;
        end
      end
      PH_FLAG: begin
        flag_bits = b;
        tok_idx = '0;
        phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (flag_bits[3'd7 - tok_idx[2:0]]) begin
          match_hi = b;
          phase = PH_MATCH2;
        end else begin
          emit_byte(b);
          advance_token();
        end
      end
      PH_MATCH2: begin
        mlen = {1'b0, match_hi[7:4]} + 5'(MATCH_LEN_BIAS);
        mdist = {1'b0, match_hi[3:0], b} + 13'd1;
        for (int k = 0; k < mlen && out_count < out_target; k++) begin
          v = 8'h00;
          if (out_count >= {8'h0, mdist}) begin
            src = out_count - {8'h0, mdist};
            v = hist_mem[src[11:0]];
          end
          emit_byte(v);
        end
        advance_token();
      end
      default: ;
    endcase
    if (decoded.size() > 0) decoded[decoded.size() - 1].last = 1'b1;
  endtask

  // Drives one byte, waits for its transfer and records what it must produce.
  task automatic send_byte(input logic [7:0] b, input logic sos, input row_t row);
    int unsigned g;
    out_item_t   o;
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    start_of_stream_i <= sos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    decode_byte(b, sos);
    if (row.typed) begin
      for (int k = 0; k < row.n; k++) begin
        o.data = row.d;
        o.last = (k == row.n - 1);
        o.eos = (k == row.n - 1) && row.eos;
        expected_bytes.push_back(o);
      end
    end else begin
      foreach (decoded[k]) expected_bytes.push_back(decoded[k]);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sos);
    stream_byte_t s;
    s.b = b;
    s.sos = sos;
    stream_bytes.push_back(s);
  endtask

  // Builds a well-formed compressed stream. It stops once the output length
  // is covered, or early after cut output bytes to leave a broken stream.
  // A deep stream uses only longest matches to pass the window with few bytes.
  task automatic build_stream(input int unsigned len, input int unsigned cut, input bit deep);
    int unsigned made;
    int unsigned stop;
    int unsigned mlen;
    int unsigned back;
    int unsigned lim;
    logic [7:0]  flags;
    logic [11:0] d;
    made = 0;
    stop = (len > CAP) ? CAP : len;
    if (cut < stop) stop = cut;
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    push_byte(len[7:0], 1'b0);
    push_byte(len[15:8], 1'b0);
    push_byte(len[23:16], 1'b0);
    while (made < stop) begin
      if (deep) flags = 8'hFF;
      else flags = 8'($urandom_range(0, 255));
      push_byte(flags, 1'b0);
      for (int i = 7; i >= 0 && made < stop; i--) begin
        if (flags[i]) begin
          mlen = deep ? 18 : $urandom_range(3, 18);
          lim = (made < WINDOW) ? made : WINDOW;
          if (made > 0 && (deep || $urandom_range(0, 99) < 85)) begin
            if (!deep && $urandom_range(0, 1) == 1) back = $urandom_range(1, (lim < 16) ? lim : 16);
            else back = $urandom_range(1, lim);
          end else begin
            back = $urandom_range(1, WINDOW);
          end
          d = 12'(back - 1);
          push_byte({4'(mlen - 3), d[11:8]}, 1'b0);
          push_byte(d[7:0], 1'b0);
          made += mlen;
        end else begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
          made++;
        end
      end
    end
  endtask

  task automatic send_stream_bytes();
    row_t plain;
    stream_byte_t s;
    plain = '0;
    while (stream_bytes.size() > 0) begin
      s = stream_bytes.pop_front();
      send_byte(s.b, s.sos, plain);
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      out_hold <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Output checker: every transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("output byte with nothing expected", out_byte_o, 0);
      end else begin
        head = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte_o !== head.data) report_mismatch("out_byte", out_byte_o, head.data);
        if (last_of_run_o !== head.last) report_mismatch("last_of_run", last_of_run_o, head.last);
        if (end_of_stream_o !== head.eos)
          report_mismatch("end_of_stream", end_of_stream_o, head.eos);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    int unsigned noise;
    phase = PH_HEADER;
    out_count = '0;
    out_target = '0;
    hdr_len = '0;
    hdr_idx = '0;
    flag_bits = '0;
    tok_idx = '0;
    match_hi = '0;
    rand_items = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_byte(directed_rows[i].b, directed_rows[i].sos,
                                         directed_rows[i]);
    streams_run += 3;

    while (rand_items < RAND_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) len = 0;
      else if (r < 12) len = $urandom_range(CAP / 2, 24'hFF_FFFF);
      else if (r < 20) len = $urandom_range(100, 400);
      else len = $urandom_range(1, 48);
      cut = (len > CAP) ? CAP : len;
      if (r >= 6 && r < 12) cut = $urandom_range(5, 60);
      else if (len > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, len - 1);
      build_stream(len, cut, 1'b0);
      rand_items += stream_bytes.size();
      // Trailing noise: parsed after a cut stream or a start mark, else ignored.
      if ($urandom_range(0, 3) == 0) begin
        noise = $urandom_range(1, 4);
        repeat (noise) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
      send_stream_bytes();
      streams_run++;
    end

    // One stream longer than the window, so matches reach across the wrap.
    calm = 1'b0;
    build_stream(DEEP_LENGTH, DEEP_LENGTH, 1'b1);
    send_stream_bytes();
    streams_run++;

    in_valid_i <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() > 0) report_mismatch("bytes never produced",
                                                   expected_bytes.size(), 0);

    $display("Sent %0d compressed bytes in %0d streams, checked %0d output bytes.",
             items_sent, streams_run, bytes_checked);
    $display("Covered literals, short and long matches, window wrap, capped and empty headers.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lzd_pkg.sv
hw/rtl/lzd_history.sv
hw/rtl/lzd_out_reg.sv
hw/rtl/lz77_stream_decompressor_top.sv
test/lz77_stream_decompressor_top_test.sv
